>>> rtl/box3_pkg.sv
// Shared types, register codes and the reciprocal table of the 3x3 box blur.
`timescale 1ns / 1ps

package box3_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Input item commands.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int SUM_W  = 12;
  localparam int NUM_W  = 13;
  localparam int CNT_W  = 4;
  localparam int RCP_W  = 17;
  localparam int RCP_SH = 17;

  typedef logic [PIX_W-1:0] pix_t;

  // Position flags of one window, fixed when the item is accepted.
  typedef struct packed {
    logic emit;
    logic top;
    logic bottom;
    logic left;
    logic right;
  } win_ctl_t;

  // ceil(2^RCP_SH / (2*n)) for each neighbor count that can occur.
  function automatic logic [RCP_W-1:0] recip_lut(input logic [CNT_W-1:0] n);
    logic [RCP_W-1:0] r;
    case (n)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd6:    r = 17'd10923;
      4'd9:    r = 17'd7282;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/box3_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module box3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/box_blur_3x3_edge_aware_unit.sv
// Streaming 3x3 box blur over RGB pixels with edge-aware averaging.
//
// Pixels enter in raster order, one item per clock when the output side keeps up.
// Each result is the rounded mean of the in-frame neighbors of a pixel and appears
// one row plus one pixel after that pixel; flush items drain the last row once the
// frame is complete. Once the item that completes its window is accepted, a result
// goes through line read with window masking, sum and reciprocal multiply.
// The two line buffers share one RAM of MAX_WIDTH entries whose read is registered;
// each item reads its column when accepted, writes it back on leaving stage 1, and
// a write-to-read bypass covers an item that reads the column being written in the
// same cycle. The line RAM is not cleared: entries not yet written only land in
// window places outside the frame. A frame-size register write restarts the frame.
`timescale 1ns / 1ps

module box_blur_3x3_edge_aware_unit #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [box3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [box3_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_command,
  input  logic [7:0]                       in_red_in,
  input  logic [7:0]                       in_green_in,
  input  logic [7:0]                       in_blue_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_red_out,
  output logic [7:0]                       out_green_out,
  output logic [7:0]                       out_blue_out,
  output logic                             out_row_end,
  output logic                             out_frame_end
);

  import box3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 3);
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [CW-1:0] W_RST = CW'((MAX_WIDTH < 640) ? MAX_WIDTH : 640);
  localparam logic [HW-1:0] H_RST = HW'((MAX_HEIGHT < 480) ? MAX_HEIGHT : 480);

  // Frame size and position counters.
  logic [CW-1:0] w_r;
  logic [HW-1:0] h_r;
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [HW-1:0] out_row_r, out_row_nxt;

  logic          cfg_we;
  logic          cfg_known;
  logic [CW-1:0] w_cfg;
  logic [HW-1:0] h_cfg;

  logic          accept;
  logic          row_in_frame;
  logic          take;
  logic          fwd_hit;
  win_ctl_t      ctl;
  pix_t          pix_in;

  // Pipeline.
  logic          s1_v_r, s2_v_r, s3_v_r, out_valid_r;
  logic          out_ld, s3_ok, s2_ok, s1_adv;
  win_ctl_t      s1_ctl_r;
  pix_t          s1_pix_r;
  logic [AW-1:0] s1_col_r;
  logic          s1_fwd_r;
  pix_t          s1_fwd_up_r, s1_fwd_mid_r;
  logic [2*PIX_W-1:0] ram_rdata;
  pix_t          above2, above1;

  pix_t          win_r   [3][3];
  pix_t          win_nxt [3][3];
  logic [2:0]    row_ok, col_ok;
  logic [1:0]    row_cnt, col_cnt;

  pix_t          s2_pix_r [3][3];
  logic [CNT_W-1:0] s2_n_r;
  logic          s2_row_end_r, s2_frame_end_r;
  logic [SUM_W-1:0] s2_sum [3];
  logic [NUM_W-1:0] s2_num [3];

  logic [NUM_W-1:0] s3_num_r [3];
  logic [RCP_W-1:0] s3_rcp_r;
  logic          s3_row_end_r, s3_frame_end_r;
  logic [NUM_W+RCP_W-1:0] prod [3];

  logic [CH_W-1:0] out_ch_r [3];
  logic          out_row_end_r, out_frame_end_r;

  // ---------------------------------------------------------------------------
  // Configuration
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign cfg_known = (cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT);

  // Sizes are stored already clamped to the supported range.
  always_comb begin
    if (cfg_data == '0) begin
      w_cfg = CW'(1);
      h_cfg = HW'(1);
    end else begin
      w_cfg = (32'(cfg_data) > 32'(MAX_WIDTH))  ? CW'(MAX_WIDTH)  : CW'(cfg_data);
      h_cfg = (32'(cfg_data) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_data);
    end
  end

  // ---------------------------------------------------------------------------
  // Item decode and position tracking, all decided at acceptance.
  assign accept       = in_valid && in_ready;
  assign row_in_frame = in_row_r < RW'(h_r);
  assign take = accept && ((in_command == CMD_FLUSH) ? !row_in_frame : row_in_frame);
  assign pix_in = (in_command == CMD_FLUSH) ? '0 : {in_red_in, in_green_in, in_blue_in};

  always_comb begin
    ctl.emit   = (in_row_r >= RW'(2)) || ((in_row_r == RW'(1)) && (in_col_r != '0));
    ctl.top    = out_row_r != '0;
    ctl.bottom = (out_row_r + HW'(1)) < h_r;
    ctl.left   = out_col_r != '0;
    ctl.right  = (out_col_r + CW'(1)) < w_r;

    if ((in_col_r + CW'(1)) >= w_r) begin
      in_col_nxt = '0;
      in_row_nxt = in_row_r + RW'(1);
    end else begin
      in_col_nxt = in_col_r + CW'(1);
      in_row_nxt = in_row_r;
    end

    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (ctl.emit) begin
      if (!ctl.right && !ctl.bottom) begin
        // The last result of the frame restarts every position counter.
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else if (!ctl.right) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + HW'(1);
      end else begin
        out_col_nxt = out_col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= W_RST;
      h_r       <= H_RST;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        w_r <= w_cfg;
      end
      if (cfg_index == REG_FRAME_HEIGHT) begin
        h_r <= h_cfg;
      end
      if (cfg_known) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
      end
    end else if (take) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: each stage moves when the one after it can take its item.
  assign out_ld   = !out_valid_r || out_ready;
  assign s3_ok    = !s3_v_r || out_ld;
  assign s2_ok    = !s2_v_r || s3_ok;
  assign s1_adv   = s1_v_r && (!s1_ctl_r.emit || s2_ok);
  assign in_ready = !s1_v_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_v_r <= take;
      end
      if (s2_ok) begin
        s2_v_r <= s1_adv && s1_ctl_r.emit;
      end
      if (s3_ok) begin
        s3_v_r <= s2_v_r;
      end
      if (out_ld) begin
        out_valid_r <= s3_v_r;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line buffers: upper row in the high half, middle row in the low half.
  box3_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata ({above1, s1_pix_r}),
    .re    (take),
    .raddr (in_col_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // The item leaving stage 1 writes the column that the new item reads.
  assign fwd_hit = s1_adv && (s1_col_r == in_col_r[AW-1:0]);
  assign above2  = s1_fwd_r ? s1_fwd_up_r  : ram_rdata[2*PIX_W-1:PIX_W];
  assign above1  = s1_fwd_r ? s1_fwd_mid_r : ram_rdata[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (take) begin
      s1_ctl_r     <= ctl;
      s1_pix_r     <= pix_in;
      s1_col_r     <= in_col_r[AW-1:0];
      s1_fwd_r     <= fwd_hit;
      s1_fwd_up_r  <= above1;
      s1_fwd_mid_r <= s1_pix_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Window shift and neighbor masking.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = above2;
    win_nxt[1][2] = above1;
    win_nxt[2][2] = s1_pix_r;
  end

  assign row_ok  = {s1_ctl_r.bottom, 1'b1, s1_ctl_r.top};
  assign col_ok  = {s1_ctl_r.right, 1'b1, s1_ctl_r.left};
  assign row_cnt = 2'd1 + 2'(s1_ctl_r.top) + 2'(s1_ctl_r.bottom);
  assign col_cnt = 2'd1 + 2'(s1_ctl_r.left) + 2'(s1_ctl_r.right);

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= win_nxt[r][c];
        end
      end
    end
    if (s1_adv && s1_ctl_r.emit && s2_ok) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          s2_pix_r[r][c] <= (row_ok[r] && col_ok[c]) ? win_nxt[r][c] : '0;
        end
      end
      s2_n_r         <= CNT_W'(row_cnt) * CNT_W'(col_cnt);
      s2_row_end_r   <= !s1_ctl_r.right;
      s2_frame_end_r <= !s1_ctl_r.right && !s1_ctl_r.bottom;
    end
  end

  // ---------------------------------------------------------------------------
  // Sums and rounding numerators: mean = (2*sum + n) / (2*n).
  always_comb begin
    logic [SUM_W-1:0] row_sum [3];
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < 3; r++) begin
        row_sum[r] = SUM_W'(s2_pix_r[r][0][PIX_W-1-CH_W*k -: CH_W])
                   + SUM_W'(s2_pix_r[r][1][PIX_W-1-CH_W*k -: CH_W])
                   + SUM_W'(s2_pix_r[r][2][PIX_W-1-CH_W*k -: CH_W]);
      end
      s2_sum[k] = row_sum[0] + row_sum[1] + row_sum[2];
      s2_num[k] = {s2_sum[k], 1'b0} + NUM_W'(s2_n_r);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && s3_ok) begin
      for (int k = 0; k < 3; k++) begin
        s3_num_r[k] <= s2_num[k];
      end
      s3_rcp_r       <= recip_lut(s2_n_r);
      s3_row_end_r   <= s2_row_end_r;
      s3_frame_end_r <= s2_frame_end_r;
    end
  end

  // Exact quotient by reciprocal: the numerator stays below 2^RCP_SH / 2n's error.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = (NUM_W+RCP_W)'(s3_num_r[k]) * (NUM_W+RCP_W)'(s3_rcp_r);
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v_r && out_ld) begin
      for (int k = 0; k < 3; k++) begin
        out_ch_r[k] <= prod[k][RCP_SH +: CH_W];
      end
      out_row_end_r   <= s3_row_end_r;
      out_frame_end_r <= s3_frame_end_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_ch_r[0];
  assign out_green_out = out_ch_r[1];
  assign out_blue_out  = out_ch_r[2];
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

  // ---------------------------------------------------------------------------
  // Checks
  a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_frame_end_r || out_row_end_r))
    else $error("frame end flagged on a result that does not end a row");

  a_in_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_row_r <= (RW'(h_r) + RW'(1)))
    else $error("input row ran more than one row past the frame");

  a_out_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_col_r < w_r)
    else $error("output column outside the frame");

  a_out_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_row_r < h_r)
    else $error("output row outside the frame");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_adv) |=> (s1_v_r && $stable(s1_col_r) && $stable(s1_pix_r)))
    else $error("stalled line item changed while it waited");

endmodule
